// ----- src/rpn_pkg.sv -----
// Shared types and codes for the RPN stack calculator.
package rpn_pkg;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_DIVZERO   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] push_value;
  } rpn_in_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [4:0]         depth;
    logic [1:0]         status;
  } rpn_out_t;

endpackage

// ----- src/rpn_alu.sv -----
// Shared arithmetic unit: registered add/sub/mul, radix-2 iterative signed divide.
module rpn_alu
  import rpn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] result
);

  logic        run;
  logic        fix;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] trial;
  logic [31:0] mag_a;
  logic [31:0] mag_b;

  assign mag_a = a[31] ? 32'(0 - a) : a;
  assign mag_b = b[31] ? 32'(0 - b) : b;
  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      fix  <= 1'b0;
      if (start) begin
        if (op == OP_DIV) begin
          run <= 1'b1;
          cnt <= 6'(DIV_STEPS);
        end else begin
          done <= 1'b1;
        end
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run <= 1'b0;
          fix <= 1'b1;
        end
      end else if (fix) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= mag_a;
      dvs <= mag_b;
      neg <= a[31] ^ b[31];
      unique case (op)
        OP_ADD:  result <= a + b;
        OP_SUB:  result <= a - b;
        OP_MUL:  result <= 32'(a * b);
        default: result <= '0;
      endcase
    end else if (run) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end else if (fix) begin
      result <= neg ? 32'(0 - quo) : quo;
    end
  end

endmodule

// ----- src/rpn_stack_mem.sv -----
// Stack storage: one write port, one read port with registered data.
module rpn_stack_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rpn_stack_calculator.sv -----
// Top level of the RPN stack calculator: sequencer, stack pointer and result register.
//
//   channel  | signals                 | handshake
//   ---------+-------------------------+---------------------------------
//   command  | cmd (opcode,push_value) | taken when start && !busy
//   result   | result (top,depth,stat) | done high for one cycle
//   config   | cfg_we, cfg_wdata       | written when cfg_we
//
// Push, refused and ignored ops go from accept through S_RDTOP and S_OUT;
// binary ops first read both operands in S_RDB, S_RDA over the single read
// port, then, but for a zero divisor, wait in S_EXEC (32-step loop for divide).
// Reset (synchronous) empties the stack and sets drop_zero_divisor to 1.
// busy stays high until the cycle done is raised; results cannot be stalled.
module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  rpn_in_t  cmd,
  output logic     busy,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  output logic     done,
  output rpn_out_t result
);

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDB   = 3'd1;
  localparam logic [2:0] S_RDA   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_RDTOP = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]     state;
  logic [SPW-1:0] sp;
  logic [2:0]     op;
  logic [1:0]     st;
  logic [31:0]    bval;
  logic           drop_zero_divisor;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [31:0]    wdata;
  logic [AW-1:0]  raddr;
  logic [31:0]    rdata;
  logic           alu_start;
  logic           alu_done;
  logic [31:0]    alu_result;
  logic           accept;
  logic           div_zero;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign div_zero = (op == OP_DIV) && (bval == 32'd0);
  assign alu_start = (state == S_RDA) && !div_zero;
  assign raddr    = (state == S_RDB) ? AW'(sp - SPW'(2)) : AW'(sp - SPW'(1));

  always_comb begin
    we    = 1'b0;
    waddr = AW'(sp);
    wdata = cmd.push_value;
    if (accept && cmd.opcode == OP_PUSH && sp < SPW'(STACK_DEPTH)) begin
      we = 1'b1;
    end else if (state == S_EXEC && alu_done) begin
      we    = 1'b1;
      waddr = AW'(sp - SPW'(2));
      wdata = alu_result;
    end
  end

  rpn_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rpn_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .start  (alu_start),
    .op     (op),
    .a      (rdata),
    .b      (bval),
    .done   (alu_done),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      sp                <= '0;
      done              <= 1'b0;
      drop_zero_divisor <= 1'b1;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        drop_zero_divisor <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= cmd.opcode;
            st <= ST_OK;
            if (cmd.opcode == OP_PUSH) begin
              if (sp < SPW'(STACK_DEPTH)) begin
                sp <= sp + SPW'(1);
              end else begin
                st <= ST_OVERFLOW;
              end
              state <= S_RDTOP;
            end else if (cmd.opcode <= OP_DIV) begin
              if (sp < SPW'(2)) begin
                st    <= ST_UNDERFLOW;
                state <= S_RDTOP;
              end else begin
                state <= S_RDB;
              end
            end else begin
              state <= S_RDTOP;
            end
          end
        end
        S_RDB: begin
          bval  <= rdata;
          state <= S_RDA;
        end
        S_RDA: begin
          if (div_zero) begin
            st <= ST_DIVZERO;
            if (drop_zero_divisor) begin
              sp <= sp - SPW'(1);
            end
            state <= S_RDTOP;
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (alu_done) begin
            sp    <= sp - SPW'(1);
            state <= S_RDTOP;
          end
        end
        S_RDTOP: begin
          state <= S_OUT;
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      result.top_value <= (sp == '0) ? 32'sd0 : $signed(rdata);
      result.depth     <= 5'(sp);
      result.status    <= st;
    end
  end

endmodule

// ----- dv/rpn_checker.sv -----
// Checker for the RPN stack calculator: tracks the stack, predicts each result and compares.
`timescale 1ns / 100ps
module rpn_checker
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  rpn_in_t  cmd,
  input  logic     busy,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     done,
  input  rpn_out_t result,
  output int       errors,
  output int       pending
);

  logic [31:0] model_stack [STACK_DEPTH];
  int unsigned model_sp;
  logic        drop_zero;
  rpn_out_t    expected_q[$];

  function automatic logic [31:0] magnitude32(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // truncating signed divide done on magnitudes so that min / -1 wraps
  function automatic logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] q;
    q = magnitude32(a) / magnitude32(b);
    return (a[31] ^ b[31]) ? (32'd0 - q) : q;
  endfunction

  function automatic rpn_out_t apply_item(rpn_in_t c);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    logic [1:0]  st;
    logic        fold;
    rpn_out_t    o;
    st   = ST_OK;
    fold = 1'b0;
    r    = '0;
    case (c.opcode)
      OP_PUSH: begin
        if (model_sp >= STACK_DEPTH) begin
          st = ST_OVERFLOW;
        end else begin
          model_stack[model_sp] = c.push_value;
          model_sp++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (model_sp < 2) begin
          st = ST_UNDERFLOW;
        end else begin
          a    = model_stack[model_sp - 2];
          b    = model_stack[model_sp - 1];
          fold = 1'b1;
          case (c.opcode)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            default: begin
              if (b == 32'd0) begin
                st   = ST_DIVZERO;
                fold = 1'b0;
                if (drop_zero) model_sp--;
              end else begin
                r = trunc_quotient(a, b);
              end
            end
          endcase
          if (fold) begin
            model_stack[model_sp - 2] = r;
            model_sp--;
          end
        end
      end
      default: ;
    endcase
    o.top_value = (model_sp > 0) ? model_stack[model_sp - 1] : '0;
    o.depth     = 5'(model_sp);
    o.status    = st;
    return o;
  endfunction

  always @(posedge clk) begin
    rpn_out_t exp_item;
    if (rst) begin
      expected_q.delete();
      model_sp  = 0;
      drop_zero = 1'b1;
      pending   = 0;
      errors    = 0;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected item top=%h depth=%0d status=%0d", $realtime,
                     result.top_value, result.depth, result.status);
        end else begin
          exp_item = expected_q.pop_front();
          if (result.top_value !== exp_item.top_value || result.depth !== exp_item.depth ||
              result.status !== exp_item.status) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp %h/%0d/%0d got %h/%0d/%0d (top/depth/status)",
                       $realtime, exp_item.top_value, exp_item.depth, exp_item.status,
                       result.top_value, result.depth, result.status);
          end
        end
      end
      if (cfg_we) drop_zero = cfg_wdata;
      if (start && !busy) expected_q.push_back(apply_item(cmd));
      pending = expected_q.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the RPN stack calculator: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import rpn_pkg::*;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     start     = 1'b0;
  rpn_in_t  cmd       = '0;
  logic     cfg_we    = 1'b0;
  logic     cfg_wdata = 1'b0;
  logic     busy;
  logic     done;
  rpn_out_t result;
  int       errors;
  int       pending;

  int items_sent = 0;
  int burst_left = 0;
  bit use_gaps   = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rpn_stack_calculator i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .result    (result)
  );

  rpn_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .result    (result),
    .errors    (errors),
    .pending   (pending)
  );

  // called at a negedge; returns at a negedge after the item is taken and any gap
  task automatic send_item(input logic [2:0] op, input logic [31:0] val);
    int gap;
    start <= 1'b1;
    cmd   <= '{opcode: op, push_value: val};
    while (busy) @(negedge clk);
    @(negedge clk);
    items_sent++;
    if (use_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 12);
        gap        = $urandom_range(1, 48);
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_drop(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5, 6:    return 32'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_binop();
    return 3'($urandom_range(OP_ADD, OP_DIV));
  endfunction

  initial begin
    int phase_start;
    int operands_left;
    int live;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty and single-entry operations, wraps, min / -1, zero divisor
    send_item(OP_ADD, 32'd0);
    send_item(OP_PUSH, 32'd0);
    send_item(OP_DIV, 32'h5555_5555);
    send_item(OP_PUSH, 32'h7FFF_FFFF);
    send_item(OP_ADD, 32'd0);
    send_item(OP_PUSH, 32'd1);
    send_item(OP_ADD, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 32'hFFFF_FFFF);
    send_item(OP_DIV, 32'd0);
    send_item(OP_PUSH, 32'hFFFF_FFFF);
    send_item(OP_MUL, 32'd0);
    send_item(OP_PUSH, 32'd7);
    send_item(OP_SUB, 32'd0);
    send_item(OP_PUSH, 32'd0);
    send_item(OP_DIV, 32'd0);
    send_item(OP_PUSH, 32'hFFFF_FFFD);
    send_item(OP_DIV, 32'd0);
    send_item(3'd5, 32'hFFFF_FFFF);
    send_item(3'd6, 32'h8000_0000);
    send_item(3'd7, 32'h7FFF_FFFF);
    send_item(OP_PUSH, 32'h8000_0000);
    send_item(OP_MUL, 32'd0);
    wait_idle();
    write_drop(1'b0);
    send_item(OP_PUSH, 32'd0);
    send_item(OP_DIV, 32'd0);
    send_item(OP_SUB, 32'd0);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_drop(ph[0]);
      use_gaps    = (ph != 3);
      burst_left  = 0;
      phase_start = items_sent;
      while (items_sent - phase_start < 300) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            operands_left = $urandom_range(2, 7);
            live          = 0;
            while (operands_left > 0 || live > 1) begin
              if (operands_left > 0 && (live < 2 || $urandom_range(0, 1))) begin
                send_item(OP_PUSH, pick_value());
                operands_left--;
                live++;
              end else begin
                send_item(pick_binop(), $urandom);
                live--;
              end
            end
          end
          6, 7: repeat ($urandom_range(1, 18)) send_item(pick_binop(), $urandom);
          8: repeat ($urandom_range(8, 20)) send_item(OP_PUSH, pick_value());
          default: repeat ($urandom_range(1, 6)) send_item(3'($urandom), $urandom);
        endcase
      end
    end

    wait_idle();
    repeat (50) @(negedge clk);
    if (errors == 0)
      $display("rpn_stack_calculator test passed");
    else
      $display("rpn_stack_calculator test failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("rpn_stack_calculator test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/rpn_pkg.sv
src/rpn_alu.sv
src/rpn_stack_mem.sv
src/rpn_stack_calculator.sv
dv/rpn_checker.sv
dv/tb_top.sv
